### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define UTLB_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the standard clk_i / rst_ni pair.
`define UTLB_ASSERT_STD(name, prop, msg) \
  `UTLB_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/utlb_pkg.sv
package utlb_pkg;

  // Table size
  localparam int unsigned ENTRIES_DEF = 64;

  // Request op codes
  localparam logic [3:0] OP_XLATE    = 4'd0;
  localparam logic [3:0] OP_WR_TAG   = 4'd1;
  localparam logic [3:0] OP_WR_PAGE  = 4'd2;
  localparam logic [3:0] OP_WR_EXTRA = 4'd3;
  localparam logic [3:0] OP_WR_CTRL  = 4'd4;
  localparam logic [3:0] OP_RD_TAG   = 4'd5;
  localparam logic [3:0] OP_RD_PAGE  = 4'd6;
  localparam logic [3:0] OP_RD_EXTRA = 4'd7;
  localparam logic [3:0] OP_RD_CTRL  = 4'd8;

  // Result status codes
  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_HIT    = 3'd0;
  localparam logic [2:0] ST_FIXED  = 3'd1;
  localparam logic [2:0] ST_ONCHIP = 3'd2;
  localparam logic [2:0] ST_OFF    = 3'd3;
  localparam logic [2:0] ST_MISS   = 3'd4;

  // Bit positions
  localparam int unsigned VALID_POS    = 8;
  localparam int unsigned CTRL_EN_POS  = 0;
  localparam int unsigned CTRL_INV_POS = 2;

  // Address masks
  localparam logic [31:0] PHYS_MASK  = 32'h1FFF_FFFF;
  localparam logic [31:0] PPN_MASK   = 32'h1FFF_FC00;
  localparam logic [31:0] ONCHIP_RES = 32'hFFFF_FFFF;

  // Page mask from the two size bits
  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    logic [31:0] m;
    case (sz)
      2'b00:   m = 32'hFFFF_FC00;
      2'b01:   m = 32'hFFFF_F000;
      2'b10:   m = 32'hFFFF_0000;
      2'b11:   m = 32'hFFF0_0000;
      default: m = 32'hFFFF_FC00;
    endcase
    return m;
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic rdata;
    logic scan;
    logic finish;
  } utlb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk;
    logic arr_rd;
    logic hit;
    logic last;
    logic out_free;
  } utlb_sts_t;

endpackage

### hw/rtl/utlb_req_if.sv
interface utlb_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [5:0]  entry;
  logic [31:0] address;
  logic [31:0] value;

  modport source (output valid, output op, output entry, output address, output value,
                  input ready);
  modport sink   (input valid, input op, input entry, input address, input value,
                  output ready);
endinterface

### hw/rtl/utlb_rsp_if.sv
interface utlb_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;
  logic [2:0]  status;

  modport source (output valid, output result_word, output status, input ready);
  modport sink   (input valid, input result_word, input status, output ready);
endinterface

### hw/rtl/utlb_ctrl.sv
module utlb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  utlb_pkg::utlb_sts_t sts_i,
  output utlb_pkg::utlb_cmd_t cmd_o
);
  import utlb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RDATA  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.walk) begin
          state_d = S_SCAN;
        end else if (sts_i.arr_rd) begin
          state_d = S_RDATA;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_RDATA: begin
        cmd_o.rdata = 1'b1;
        state_d     = S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit || sts_i.last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/utlb_datapath.sv
module utlb_datapath #(
  parameter int unsigned NumEntries = utlb_pkg::ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utlb_pkg::utlb_cmd_t cmd_i,
  output utlb_pkg::utlb_sts_t sts_o,
  input  logic [3:0]          op_i,
  input  logic [5:0]          entry_i,
  input  logic [31:0]         address_i,
  input  logic [31:0]         value_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [31:0]         result_word_o,
  output logic [2:0]          status_o
);
  import utlb_pkg::*;

  localparam int unsigned IdxW = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumEntries - 1);

  // Latched request
  logic [3:0]  op_q;
  logic [5:0]  entry_q;
  logic [31:0] addr_q, value_q;

  // Architectural state
  logic [31:0] ctrl_q;
  logic [31:0] tag_mem   [NumEntries];
  logic [31:0] page_mem  [NumEntries];
  logic [31:0] extra_mem [NumEntries];
  logic [NumEntries-1:0] vld_q, tag_wr_q, page_wr_q, extra_wr_q;

  // Read port registers
  logic [31:0] tag_rd_q, page_rd_q, extra_rd_q;
  logic        tag_ok_q, vld_rd_q, page_ok_q, extra_ok_q;

  // Walk and result
  logic [IdxW-1:0] idx_q, idx_d, rd_addr;
  logic [31:0]     res_q, res_d;
  logic [2:0]      st_q, st_d;
  logic            out_valid_q;
  logic [31:0]     out_res_q;
  logic [2:0]      out_st_q;

  logic            entry_ok, is_p12, is_p4, xlate_on, walk, arr_rd, hit, last, out_free;
  logic [IdxW-1:0] entry_idx;
  logic [31:0]     tag_eff, page_eff, extra_eff, pmask;
  logic            we_tag, we_page, we_extra, we_ctrl;

  // Request decode
  assign entry_ok  = ({1'b0, entry_q} < 7'(NumEntries));
  assign entry_idx = entry_q[IdxW-1:0];
  assign is_p12    = (addr_q[31:30] == 2'b10);
  assign is_p4     = (addr_q[31:29] == 3'b111);
  assign xlate_on  = ctrl_q[CTRL_EN_POS];
  assign walk      = (op_q == OP_XLATE) && !is_p12 && !is_p4 && xlate_on;
  assign arr_rd    = ((op_q == OP_RD_TAG) || (op_q == OP_RD_PAGE) || (op_q == OP_RD_EXTRA))
                     && entry_ok;

  assign we_tag   = cmd_i.exec && (op_q == OP_WR_TAG) && entry_ok;
  assign we_page  = cmd_i.exec && (op_q == OP_WR_PAGE) && entry_ok;
  assign we_extra = cmd_i.exec && (op_q == OP_WR_EXTRA) && entry_ok;
  assign we_ctrl  = cmd_i.exec && (op_q == OP_WR_CTRL);

  // Read address: prefetch the next entry while the walk compares this one
  always_comb begin
    if (cmd_i.scan) begin
      rd_addr = (idx_q == LastIdx) ? idx_q : IdxW'(idx_q + 1'b1);
    end else if (walk) begin
      rd_addr = '0;
    end else begin
      rd_addr = entry_idx;
    end
  end

  // Entries never written read as zero; bit 8 of a tag comes from the valid flops
  assign tag_eff   = tag_ok_q ? {tag_rd_q[31:9], vld_rd_q, tag_rd_q[7:0]} : '0;
  assign page_eff  = page_ok_q ? page_rd_q : '0;
  assign extra_eff = extra_ok_q ? extra_rd_q : '0;

  // Entry compare
  assign pmask = size_mask({page_eff[7], page_eff[4]});
  assign hit   = tag_eff[VALID_POS] && ((addr_q & pmask) == (tag_eff & pmask));
  assign last  = (idx_q == LastIdx);

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.walk     = walk;
  assign sts_o.arr_rd   = arr_rd;
  assign sts_o.hit      = hit;
  assign sts_o.last     = last;
  assign sts_o.out_free = out_free;

  // Result computation
  always_comb begin
    res_d = res_q;
    st_d  = st_q;
    idx_d = idx_q;
    if (cmd_i.exec) begin
      res_d = '0;
      st_d  = ST_NONE;
      idx_d = '0;
      case (op_q)
        OP_XLATE: begin
          if (is_p12) begin
            res_d = addr_q & PHYS_MASK;
            st_d  = ST_FIXED;
          end else if (is_p4) begin
            res_d = ONCHIP_RES;
            st_d  = ST_ONCHIP;
          end else if (!xlate_on) begin
            res_d = addr_q & PHYS_MASK;
            st_d  = ST_OFF;
          end
        end
        OP_RD_CTRL: res_d = ctrl_q;
        default: ;
      endcase
    end
    if (cmd_i.rdata) begin
      case (op_q)
        OP_RD_TAG:   res_d = tag_eff;
        OP_RD_PAGE:  res_d = page_eff;
        OP_RD_EXTRA: res_d = extra_eff;
        default: ;
      endcase
    end
    if (cmd_i.scan) begin
      if (hit) begin
        res_d = (page_eff & PPN_MASK) | (addr_q & ~pmask);
        st_d  = ST_HIT;
      end else if (last) begin
        res_d = addr_q & PHYS_MASK;
        st_d  = ST_MISS;
      end else begin
        idx_d = IdxW'(idx_q + 1'b1);
      end
    end
  end

  // Payload registers and memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= op_i;
      entry_q <= entry_i;
      addr_q  <= address_i;
      value_q <= value_i;
    end
    res_q <= res_d;
    st_q  <= st_d;
    idx_q <= idx_d;
    if (we_tag)   tag_mem[entry_idx]   <= value_q;
    if (we_page)  page_mem[entry_idx]  <= value_q;
    if (we_extra) extra_mem[entry_idx] <= value_q;
    tag_rd_q   <= tag_mem[rd_addr];
    page_rd_q  <= page_mem[rd_addr];
    extra_rd_q <= extra_mem[rd_addr];
    tag_ok_q   <= tag_wr_q[rd_addr];
    vld_rd_q   <= vld_q[rd_addr];
    page_ok_q  <= page_wr_q[rd_addr];
    extra_ok_q <= extra_wr_q[rd_addr];
    if (cmd_i.finish && out_free) begin
      out_res_q <= res_q;
      out_st_q  <= st_q;
    end
  end

  // Control word, valid and written flags, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      vld_q       <= '0;
      tag_wr_q    <= '0;
      page_wr_q   <= '0;
      extra_wr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (we_ctrl) begin
        ctrl_q <= {value_q[31:3], 1'b0, value_q[1:0]};
        if (value_q[CTRL_INV_POS]) begin
          vld_q <= '0;
        end
      end
      if (we_tag) begin
        tag_wr_q[entry_idx] <= 1'b1;
        vld_q[entry_idx]    <= value_q[VALID_POS];
      end
      if (we_page) begin
        page_wr_q[entry_idx] <= 1'b1;
      end
      if (we_extra) begin
        extra_wr_q[entry_idx] <= 1'b1;
      end
      if (cmd_i.finish && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_word_o = out_res_q;
  assign status_o      = out_st_q;

endmodule

### hw/rtl/utlb_address_translation.sv
// Unified TLB: NumEntries fully associative entries with memory-mapped
// access to the tag, page and extra arrays and to the control word.
// Requests arrive on req_i (valid/ready) and each one produces exactly one
// response on rsp_o (valid/ready) holding result_word and status.
// Writes, control accesses, fixed-area and translation-off requests pass
// through EXEC and FINISH; array reads add RDATA between the two; a table
// walk adds SCAN, which runs until an entry hits or the last entry misses.
// The walk checks one entry per cycle, limited by the single read port of
// the tag and page memories.
// One request is in flight at a time; req_i.ready is high only when idle,
// so a new request is taken only once the previous one has left FINISH.
// Reset clears the control word, every valid bit and the written flags, so
// all array entries read as zero right away; no clearing pass is needed.
// When rsp_o stalls the response is held in the output register; the block
// still accepts and works the next request and then waits for the output
// register before its response is posted.
`include "assert_macros.svh"

module utlb_address_translation #(
  parameter int unsigned NumEntries = utlb_pkg::ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  utlb_req_if.sink          req_i,
  utlb_rsp_if.source        rsp_o
);
  import utlb_pkg::*;

  utlb_cmd_t cmd;
  utlb_sts_t sts;
  logic      req_ready;

  assign req_i.ready = req_ready;

  // Sequencer
  utlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arrays, compare and result path
  utlb_datapath #(
    .NumEntries (NumEntries)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (req_i.op),
    .entry_i       (req_i.entry),
    .address_i     (req_i.address),
    .value_i       (req_i.value),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .result_word_o (rsp_o.result_word),
    .status_o      (rsp_o.status)
  );

  // Checks
  `UTLB_ASSERT_STD(a_cmd_onehot, $onehot0(cmd), "more than one command active")
  `UTLB_ASSERT_STD(a_accept_exec, (req_i.valid && req_i.ready) |=> cmd.exec, "exec missing")
  `UTLB_ASSERT(a_scan_busy, clk_i, rst_ni, cmd.scan |-> !req_i.ready, "accept during walk")
  `UTLB_ASSERT_STD(a_finish_post, (cmd.finish && sts.out_free) |=> rsp_o.valid, "not posted")

endmodule

### tb/sv/utlb_xlate_checker.sv
// Watches both channels of the TLB, keeps a shadow copy of the arrays and the
// control word, works out the response of every accepted request and checks
// each accepted response against the oldest one still owed.
module utlb_xlate_checker (
  input  logic clk_i,
  input  logic rst_ni,
  utlb_req_if  req_i,
  utlb_rsp_if  rsp_i,
  output int   failures_o,
  output int   pending_o
);
  import utlb_pkg::*;

  localparam int unsigned Depth = ENTRIES_DEF;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  status;
  } tlb_rsp_t;

  // Shadow state
  logic [31:0] tag_mem   [Depth];
  logic [31:0] page_mem  [Depth];
  logic [31:0] extra_mem [Depth];
  logic [31:0] ctrl_q;

  tlb_rsp_t rsp_owed[$];
  tlb_rsp_t due;
  int       fail_cnt;
  int       k;

  // Address translation against the shadow table
  function automatic tlb_rsp_t translate_va(input logic [31:0] va);
    tlb_rsp_t    r;
    logic [31:0] m;
    logic        found;
    int          i;
    r.word = va & PHYS_MASK;
    r.status = ST_MISS;
    found = 1'b0;
    m = 32'hFFFF_FC00;
    if (va[31:30] == 2'b10) begin
      r.status = ST_FIXED;
    end else if (va[31:29] == 3'b111) begin
      r.word = ONCHIP_RES;
      r.status = ST_ONCHIP;
    end else if (!ctrl_q[CTRL_EN_POS]) begin
      r.status = ST_OFF;
    end else begin
      // lowest valid matching entry wins
      for (i = 0; i < Depth; i++) begin
        if (!found && tag_mem[i][VALID_POS]) begin
          case ({page_mem[i][7], page_mem[i][4]})
            2'b00:   m = 32'hFFFF_FC00;
            2'b01:   m = 32'hFFFF_F000;
            2'b10:   m = 32'hFFFF_0000;
            default: m = 32'hFFF0_0000;
          endcase
          if ((va & m) == (tag_mem[i] & m)) begin
            found = 1'b1;
            // page bits inside the offset stay set
            r.word = (page_mem[i] & PPN_MASK) | (va & ~m);
            r.status = ST_HIT;
          end
        end
      end
    end
    return r;
  endfunction

  // Applies one request to the shadow state and returns its response
  function automatic tlb_rsp_t tlb_access(input logic [3:0]  op,
                                          input logic [5:0]  idx,
                                          input logic [31:0] va,
                                          input logic [31:0] wdata);
    tlb_rsp_t r;
    logic     ok;
    int       i;
    r.word = '0;
    r.status = ST_NONE;
    ok = (idx < Depth);
    case (op)
      OP_XLATE:    r = translate_va(va);
      OP_WR_TAG:   if (ok) tag_mem[idx] = wdata;
      OP_WR_PAGE:  if (ok) page_mem[idx] = wdata;
      OP_WR_EXTRA: if (ok) extra_mem[idx] = wdata;
      OP_WR_CTRL: begin
        ctrl_q = wdata;
        // invalidate all: drop every valid bit, the bit itself reads 0
        if (wdata[CTRL_INV_POS]) begin
          for (i = 0; i < Depth; i++) tag_mem[i][VALID_POS] = 1'b0;
          ctrl_q[CTRL_INV_POS] = 1'b0;
        end
      end
      OP_RD_TAG:   r.word = ok ? tag_mem[idx] : '0;
      OP_RD_PAGE:  r.word = ok ? page_mem[idx] : '0;
      OP_RD_EXTRA: r.word = ok ? extra_mem[idx] : '0;
      OP_RD_CTRL:  r.word = ctrl_q;
      default: ;
    endcase
    return r;
  endfunction

  // Response check first, then the new request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (k = 0; k < Depth; k++) begin
        tag_mem[k] = '0;
        page_mem[k] = '0;
        extra_mem[k] = '0;
      end
      ctrl_q = '0;
      rsp_owed.delete();
      fail_cnt = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (rsp_owed.size() == 0) begin
          $error("response with no request outstanding: result_word %h status %0d",
                 rsp_i.result_word, rsp_i.status);
          fail_cnt++;
        end else begin
          due = rsp_owed.pop_front();
          if (rsp_i.result_word !== due.word) begin
            $error("result_word mismatch: expected %h, got %h", due.word, rsp_i.result_word);
            fail_cnt++;
          end
          if (rsp_i.status !== due.status) begin
            $error("status mismatch: expected %0d, got %0d", due.status, rsp_i.status);
            fail_cnt++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        rsp_owed.push_back(tlb_access(req_i.op, req_i.entry, req_i.address, req_i.value));
      end
    end
    failures_o <= fail_cnt;
    pending_o <= rsp_owed.size();
  end

endmodule

### tb/sv/tb.sv
// Drives requests into the TLB and takes its responses with random gaps on
// both sides; the checker beside the block does the comparing.
module tb;
  import utlb_pkg::*;

  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam int         PhaseItems  = 280;
  localparam int         HoldOff     = 240;
  localparam int         Drain       = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   hold_off_go;
  int   failures;
  int   pending;
  int   ph;
  int   n;

  // tags as last written, used to aim translations at live pages
  logic [31:0] tag_log [ENTRIES_DEF];

  utlb_req_if req ();
  utlb_rsp_if rsp ();

  utlb_address_translation uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  utlb_xlate_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rsp_i      (rsp),
    .failures_o (failures),
    .pending_o  (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Response side: random ready, with one long hold-off on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        rsp.ready = 1'b0;
        repeat (HoldOff) @(negedge clk_i);
      end
      rsp.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [3:0]  op,
                              input logic [5:0]  idx,
                              input logic [31:0] va,
                              input logic [31:0] wdata);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.valid = 1'b1;
    req.op = op;
    req.entry = idx;
    req.address = va;
    req.value = wdata;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Mostly table setup and translations that land on written pages
  task automatic random_request();
    logic [3:0]  op;
    logic [5:0]  idx;
    logic [31:0] va;
    logic [31:0] wd;
    int          pick;
    pick = $urandom_range(99);
    idx = 6'($urandom_range(ENTRIES_DEF - 1));
    va = $urandom;
    wd = $urandom;
    op = OP_XLATE;
    if (pick < 50) begin
      if ($urandom_range(9) < 6) begin
        va[31:10] = tag_log[idx][31:10];
        if ($urandom_range(2) == 0) va[19:10] = 10'($urandom);
      end
    end else if (pick < 62) begin
      // keep the page in P0 or P3 so it can be hit
      if ($urandom_range(1) == 0) wd[31] = 1'b0;
      else wd[31:29] = 3'b110;
      wd[VALID_POS] = ($urandom_range(9) != 0);
      tag_log[idx] = wd;
      op = OP_WR_TAG;
    end else if (pick < 72) begin
      op = OP_WR_PAGE;
    end else if (pick < 76) begin
      op = OP_WR_EXTRA;
    end else if (pick < 88) begin
      op = 4'($urandom_range(OP_RD_CTRL, OP_RD_TAG));
    end else if (pick < 94) begin
      wd[CTRL_EN_POS] = ($urandom_range(99) < 85);
      if ($urandom_range(4) != 0) wd[CTRL_INV_POS] = 1'b0;
      op = OP_WR_CTRL;
    end else begin
      op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    end
    send_request(op, idx, va, wd);
  endtask

  initial begin
    req.valid = 1'b0;
    req.op = OP_XLATE;
    req.entry = '0;
    req.address = '0;
    req.value = '0;
    tx_idle_pct = 19;
    rx_idle_pct = 58;
    hold_off_go = 1'b0;
    for (n = 0; n < ENTRIES_DEF; n++) tag_log[n] = '0;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset state, area boundaries, translation off
    send_request(OP_RD_CTRL,  6'd0,  32'h0, 32'h0);
    send_request(OP_RD_TAG,   6'd63, 32'h0, 32'h0);
    send_request(OP_XLATE,    6'd0,  32'h0000_0000, 32'h0);
    send_request(OP_XLATE,    6'd0,  32'hDFFF_FFFF, 32'h0);
    send_request(OP_XLATE,    6'd0,  32'h8000_0000, 32'h0);
    send_request(OP_XLATE,    6'd0,  32'hBFFF_FFFF, 32'h0);
    send_request(OP_XLATE,    6'd0,  32'hE000_0000, 32'h0);
    send_request(OP_XLATE,    6'd0,  32'hFFFF_FFFF, 32'h0);
    // 1M page in the last entry, all page bits set so the offset is ORed
    send_request(OP_WR_TAG,   6'd63, 32'h0, 32'h1234_5500);
    send_request(OP_WR_PAGE,  6'd63, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_WR_EXTRA, 6'd0,  32'h0, 32'hFFFF_FFFF);
    send_request(OP_WR_CTRL,  6'd0,  32'h0, 32'h0000_0001);
    send_request(OP_XLATE,    6'd0,  32'h1234_5678, 32'h0);
    // 4K page in entry 0 overlapping the last one: lowest entry wins
    send_request(OP_WR_TAG,   6'd0,  32'h0, 32'h1230_0100);
    send_request(OP_WR_PAGE,  6'd0,  32'h0, 32'h0ABC_D010);
    send_request(OP_XLATE,    6'd0,  32'h1230_0ABC, 32'h0);
    send_request(OP_XLATE,    6'd0,  32'h7FFF_FFFF, 32'h0);
    send_request(OP_RD_TAG,   6'd0,  32'h0, 32'h0);
    send_request(OP_RD_PAGE,  6'd63, 32'h0, 32'h0);
    send_request(OP_RD_EXTRA, 6'd0,  32'h0, 32'h0);
    // invalidate all, then the old page must miss
    send_request(OP_WR_CTRL,  6'd0,  32'h0, 32'hFFFF_FFFF);
    send_request(OP_RD_CTRL,  6'd0,  32'h0, 32'h0);
    send_request(OP_RD_TAG,   6'd63, 32'h0, 32'h0);
    send_request(OP_XLATE,    6'd0,  32'h1234_5678, 32'h0);
    send_request(OP_SPARE_HI, 6'd0,  32'h0, 32'h0);

    // Random phases: sender-light, receiver-light, then no gaps at all
    for (ph = 0; ph < 3; ph++) begin
      wait_drained();
      tx_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 58 : 0;
      rx_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 19 : 0;
      for (n = 0; n < PhaseItems; n++) begin
        if (n == 40 && ph != 1) hold_off_go = 1'b1;
        random_request();
      end
    end

    wait_drained();
    repeat (Drain) @(negedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
